// ===== sv/ada_pkg.sv =====
// ada_pkg: shared types, constants and table builders for the atmosphere density core
// used by atmosphere_density_at_altitude_core, ada_log2 and ada_div; no dependencies
package ada_pkg;

    typedef struct packed {
        logic [16:0] altitude_m;
        logic [15:0] ground_temp;
        logic [23:0] ground_pressure;
    } query_t;

    typedef struct packed {
        logic [1:0]  layer;
        logic        above_ceiling;
        logic [15:0] temp_at_alt;
        logic [23:0] pressure_at_alt;
        logic [21:0] air_density;
    } result_t;

    typedef enum logic [1:0] {
        LAYER_TROPO,
        LAYER_LOWER,
        LAYER_UPPER,
        LAYER_CEIL
    } layer_t;

    localparam int LOG_FRAC = 20;
    localparam int LOG_W    = 25;
    localparam int ROM_W    = 21;
    localparam int NUM_W    = 37;
    localparam int QUO_W    = 22;
    localparam int DIV_BITS = 2;

    localparam logic [23:0] P_MAX   = 24'hFFFFFF;
    localparam logic [21:0] RHO_MAX = 22'h3FFFFF;
    localparam logic [28:0] RHO_K   = 29'd467820590;

    localparam logic [16:0] ALT_TROPO_TOP = 17'd11000;
    localparam logic [16:0] ALT_LOWER_TOP = 17'd25000;
    localparam logic [16:0] ALT_CEILING   = 17'd100000;

    localparam logic [15:0] TROPO_LAPSE = 16'd54442;
    localparam logic [15:0] UPPER_RISE  = 16'd25082;
    localparam logic [15:0] UPPER_BASE  = 16'd18168;
    localparam logic [15:0] LOWER_TEMP  = 16'd27736;
    localparam logic [19:0] LOWER_SLOPE = 20'd972824;
    localparam int          LOWER_OFS   = 2617101;

    localparam int TROPO_REF_T   = 36874;
    localparam int UPPER_REF_T   = 27725;
    localparam int LOWER_P_SCALE = 1484390;
    localparam int UPPER_P_SCALE = 163054;

    localparam logic [20:0] TROPO_EXP = 21'd344457;
    localparam logic [20:0] UPPER_EXP = 21'd746324;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bv;
        logic [63:0] rest;
        r    = '0;
        bv   = 64'h4000_0000_0000_0000;
        rest = v;
        for (int k = 0; k < 32; k++)
        begin
            if (rest >= r + bv)
            begin
                rest = rest - (r + bv);
                r    = (r >> 1) + bv;
            end
            else
            begin
                r = r >> 1;
            end
            bv = bv >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/2^n) in q20 by repeated squaring
    function automatic logic [ROM_W-1:0] log_rom_val(input int n, input int i);
        logic [63:0]      m;
        logic [ROM_W-1:0] r;
        r = '0;
        m = (64'd1 << 30) + (64'(i) << (30 - n));
        if (i >= (1 << n))
        begin
            r = ROM_W'(1 << LOG_FRAC);
        end
        else
        begin
            for (int k = 0; k < LOG_FRAC; k++)
            begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd1 << 31))
                begin
                    r[0] = 1'b1;
                    m    = m >> 1;
                end
            end
        end
        return r;
    endfunction

    // 2^(i/2^n) in q30 from a chain of square roots
    function automatic logic [31:0] exp_rom_val(input int n, input int i);
        logic [63:0] m;
        logic [63:0] root;
        m    = 64'd1 << 30;
        root = 64'd1 << 31;
        if (i >= (1 << n))
        begin
            m = 64'd1 << 31;
        end
        else
        begin
            for (int k = 1; k <= n; k++)
            begin
                root = isqrt64(root << 30);
                if (((i >> (n - k)) & 1) != 0)
                begin
                    m = (m * root) >> 30;
                end
            end
        end
        return 32'(m);
    endfunction

    // elaboration-time log2 of a constant, same arithmetic as the datapath
    function automatic logic [LOG_W-1:0] log2_const(input int n, input int x);
        int          p;
        logic [63:0] f;
        logic [63:0] rem;
        logic [63:0] a;
        logic [63:0] b;
        int          idx;
        p = 0;
        for (int k = 0; k < 31; k++)
        begin
            if (((x >> k) & 1) != 0)
            begin
                p = k;
            end
        end
        f   = (64'(x) - (64'd1 << p)) << (32 - p);
        idx = int'(f >> (32 - n));
        rem = f & ((64'd1 << (32 - n)) - 64'd1);
        a   = 64'(log_rom_val(n, idx));
        b   = 64'(log_rom_val(n, idx + 1));
        return LOG_W'((64'(p) << LOG_FRAC) + a + (((b - a) * rem) >> (32 - n)));
    endfunction

endpackage

// ===== sv/atmosphere_density_at_altitude_core.sv =====
// atmosphere_density_at_altitude_core: three-layer atmosphere, temperature, pressure, density
// depends on ada_pkg, ada_log2 and ada_div
//
//   channel  signals                            word      direction
//   query    query_valid query_stall query      query_t   in
//   result   result_valid result_stall result   result_t  out
//
// one word enters per cycle while query_stall is low; results leave in query order
// the pipe is built from two log2 units (4 stages), the exp2 table path and the divider
// (12 stages); all stages move together when the output register is free or taken
// rst_n clears only the stage valid bits; no tables or memories need clearing
// a stalled result holds the whole pipe and raises query_stall
module atmosphere_density_at_altitude_core #(
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  ada_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output ada_pkg::result_t result
);
    import ada_pkg::*;

    localparam int N       = TABLE_ADDR_BITS;
    localparam int ERW     = LOG_FRAC - N;
    localparam int ENTRIES = (1 << N) + 1;
    localparam int STAGES  = 25;
    localparam int SIDE_N  = 24;

    localparam logic [LOG_W-1:0] LOG_TROPO_REF = log2_const(N, TROPO_REF_T);
    localparam logic [LOG_W-1:0] LOG_UPPER_REF = log2_const(N, UPPER_REF_T);
    localparam logic signed [31:0] K_LOWER =
        32'(log2_const(N, LOWER_P_SCALE)) + 32'(LOWER_OFS);
    localparam logic signed [31:0] K_UPPER = 32'(log2_const(N, UPPER_P_SCALE));

    typedef struct packed {
        layer_t      layer;
        logic [15:0] temp;
        logic        pzero;
        logic [24:0] hterm;
        logic [23:0] pres;
    } side_t;

    logic [31:0] exp_rom [0:ENTRIES-1];

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_exp_rom
        assign exp_rom[g] = exp_rom_val(N, g);
    end

    logic               adv;
    logic [STAGES:1]    v_reg;
    side_t              side_reg  [1:SIDE_N];
    side_t              side_next [1:SIDE_N];

    // stage 1
    side_t              s1;
    logic [33:0]        drop_prod;
    logic [32:0]        up_prod;
    logic [36:0]        h_prod;
    logic [15:0]        tropo_t;
    logic [23:0]        p0_reg;

    // stages 2..5
    logic [LOG_W-1:0]   logt;
    logic [LOG_W-1:0]   logp;

    // stage 6
    logic signed [25:0] diff;
    logic signed [21:0] coef;
    logic signed [46:0] prod6_next;
    logic signed [46:0] prod6_reg;
    logic [LOG_W-1:0]   logp6_reg;

    // stage 7
    logic signed [30:0] mq;
    logic signed [31:0] e7_next;
    logic signed [31:0] e7_reg;

    // stage 8
    logic [11:0]        ip;
    logic [N-1:0]       eidx;
    logic [31:0]        a8_reg;
    logic [31:0]        d8_reg;
    logic [ERW-1:0]     rem8_reg;
    logic               neg8_reg;
    logic               sat8_reg;
    logic [4:0]         sh8_reg;

    // stage 9
    logic [32+ERW-1:0]  prod9;
    logic [31:0]        m9_reg;
    logic               neg9_reg;
    logic               sat9_reg;
    logic [4:0]         sh9_reg;

    // stage 10
    logic [23:0]        pres10;

    // stages 11, 12
    logic [40:0]        plo11_reg;
    logic [40:0]        phi11_reg;
    logic [52:0]        full12;
    logic [NUM_W-1:0]   num12_reg;

    // stages 13..24
    logic [QUO_W-1:0]   quo;
    logic               ovf;

    // stage 25
    result_t            result_reg;
    result_t            result_next;

    assign adv          = !v_reg[STAGES] || !result_stall;
    assign query_stall  = !adv;
    assign result_valid = v_reg[STAGES];
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-1:1], query_valid};
        end
    end

    // layer, temperature and lower-layer exponent slope
    always_comb
    begin
        drop_prod = 34'(query.altitude_m) * 34'(TROPO_LAPSE) + 34'(32768);
        up_prod   = 33'(query.altitude_m) * 33'(UPPER_RISE) + 33'(32768);
        h_prod    = 37'(query.altitude_m) * 37'(LOWER_SLOPE);
        tropo_t   = (17'(query.ground_temp) > drop_prod[32:16])
                    ? query.ground_temp - drop_prod[31:16] : 16'd0;
        s1.hterm  = h_prod[36:12];
        s1.pres   = '0;
        if (query.altitude_m <= ALT_TROPO_TOP)
        begin
            s1.layer = LAYER_TROPO;
            s1.temp  = tropo_t;
            s1.pzero = (tropo_t == 16'd0) || (query.ground_pressure == 24'd0);
        end
        else if (query.altitude_m <= ALT_LOWER_TOP)
        begin
            s1.layer = LAYER_LOWER;
            s1.temp  = LOWER_TEMP;
            s1.pzero = 1'b0;
        end
        else if (query.altitude_m <= ALT_CEILING)
        begin
            s1.layer = LAYER_UPPER;
            s1.temp  = UPPER_BASE + up_prod[31:16];
            s1.pzero = 1'b0;
        end
        else
        begin
            s1.layer = LAYER_CEIL;
            s1.temp  = '0;
            s1.pzero = 1'b1;
        end
    end

    ada_log2 #(
        .W              (16),
        .TABLE_ADDR_BITS(N)
    ) u_log_t (
        .clk(clk),
        .en (adv),
        .x  (side_reg[1].temp),
        .y  (logt)
    );

    ada_log2 #(
        .W              (24),
        .TABLE_ADDR_BITS(N)
    ) u_log_p (
        .clk(clk),
        .en (adv),
        .x  (p0_reg),
        .y  (logp)
    );

    // scaled temperature ratio times the power-law exponent
    always_comb
    begin
        if (side_reg[5].layer == LAYER_UPPER)
        begin
            diff = $signed({1'b0, logt}) - $signed({1'b0, LOG_UPPER_REF});
            coef = $signed({1'b0, UPPER_EXP});
        end
        else
        begin
            diff = $signed({1'b0, logt}) - $signed({1'b0, LOG_TROPO_REF});
            coef = $signed({1'b0, TROPO_EXP});
        end
        prod6_next = diff * coef;
    end

    // divide by 2^16 rounding toward zero, then form the exp2 argument
    always_comb
    begin
        mq = 31'(prod6_reg >>> 16);
        if (prod6_reg[46] && (prod6_reg[15:0] != 16'd0))
        begin
            mq = mq + 31'sd1;
        end
        case (side_reg[6].layer)
            LAYER_TROPO: e7_next = $signed({7'd0, logp6_reg}) + 32'(mq);
            LAYER_LOWER: e7_next = K_LOWER - $signed({7'd0, side_reg[6].hterm});
            LAYER_UPPER: e7_next = K_UPPER - 32'(mq);
            default:     e7_next = '0;
        endcase
    end

    assign ip    = e7_reg[31:20];
    assign eidx  = e7_reg[LOG_FRAC-1 -: N];
    assign prod9 = (32 + ERW)'(d8_reg) * (32 + ERW)'(rem8_reg);

    // integer part of 24 or more saturates the pressure code unless pzero forces zero
    always_comb
    begin
        if (side_reg[9].pzero || neg9_reg)
        begin
            pres10 = '0;
        end
        else if (sat9_reg)
        begin
            pres10 = P_MAX;
        end
        else
        begin
            pres10 = 24'(m9_reg >> sh9_reg);
        end
    end

    assign full12 = (53'(phi11_reg) << 12) + 53'(plo11_reg);

    ada_div u_div (
        .clk(clk),
        .en (adv),
        .num(num12_reg),
        .den(side_reg[12].temp),
        .quo(quo),
        .ovf(ovf)
    );

    always_comb
    begin
        side_next[1] = s1;
        for (int s = 2; s <= SIDE_N; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[10].pres = pres10;
    end

    always_comb
    begin
        result_next.layer           = 2'(side_reg[SIDE_N].layer);
        result_next.above_ceiling   = (side_reg[SIDE_N].layer == LAYER_CEIL);
        result_next.temp_at_alt     = side_reg[SIDE_N].temp;
        result_next.pressure_at_alt = side_reg[SIDE_N].pres;
        if (side_reg[SIDE_N].temp == 16'd0)
        begin
            result_next.air_density = '0;
        end
        else if (ovf)
        begin
            result_next.air_density = RHO_MAX;
        end
        else
        begin
            result_next.air_density = quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 1; s <= SIDE_N; s++)
            begin
                side_reg[s] <= side_next[s];
            end
            p0_reg     <= query.ground_pressure;
            prod6_reg  <= prod6_next;
            logp6_reg  <= logp;
            e7_reg     <= e7_next;
            a8_reg     <= exp_rom[eidx];
            d8_reg     <= exp_rom[(N+1)'(eidx) + (N+1)'(1)] - exp_rom[eidx];
            rem8_reg   <= e7_reg[ERW-1:0];
            neg8_reg   <= e7_reg[31];
            sat8_reg   <= !e7_reg[31] && (ip >= 12'd24);
            sh8_reg    <= 5'(12'd30 - ip);
            m9_reg     <= a8_reg + prod9[32+ERW-1:ERW];
            neg9_reg   <= neg8_reg;
            sat9_reg   <= sat8_reg;
            sh9_reg    <= sh8_reg;
            plo11_reg  <= 41'(side_reg[10].pres[11:0]) * 41'(RHO_K);
            phi11_reg  <= 41'(side_reg[10].pres[23:12]) * 41'(RHO_K);
            num12_reg  <= full12[52:16];
            result_reg <= result_next;
        end
    end

endmodule

// ===== sv/ada_log2.sv =====
// ada_log2: four-stage q20 log2 unit, leading one, normalize, table read, interpolate
// depends on ada_pkg for the table builder and widths
module ada_log2 #(
    parameter int W = 16,
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [W-1:0]              x,
    output logic [ada_pkg::LOG_W-1:0] y
);
    import ada_pkg::*;

    localparam int N       = TABLE_ADDR_BITS;
    localparam int PW      = $clog2(W);
    localparam int RW      = 32 - N;
    localparam int ENTRIES = (1 << N) + 1;

    logic [ROM_W-1:0] rom [0:ENTRIES-1];

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_rom
        assign rom[g] = log_rom_val(N, g);
    end

    logic [W-1:0]       x1_reg;
    logic [PW-1:0]      p1_reg;
    logic [PW-1:0]      p1_next;
    logic [PW-1:0]      p2_reg;
    logic [N-1:0]       idx2_reg;
    logic [RW-1:0]      rem2_reg;
    logic [63:0]        norm;
    logic [PW-1:0]      p3_reg;
    logic [ROM_W-1:0]   a3_reg;
    logic [ROM_W-1:0]   d3_reg;
    logic [RW-1:0]      rem3_reg;
    logic [ROM_W+RW-1:0] interp;
    logic [LOG_W-1:0]   y_reg;
    logic [LOG_W-1:0]   y_next;

    always_comb
    begin
        p1_next = '0;
        for (int k = 0; k < W; k++)
        begin
            if (x[k])
            begin
                p1_next = PW'(k);
            end
        end
    end

    // msb drops off the top, leaving the fraction in 32 bits
    assign norm = 64'(x1_reg) << (7'd32 - 7'(p1_reg));

    assign interp = (ROM_W + RW)'(d3_reg) * (ROM_W + RW)'(rem3_reg);
    assign y_next = (LOG_W'(p3_reg) << LOG_FRAC) + LOG_W'(a3_reg)
                    + LOG_W'(interp[ROM_W+RW-1:RW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x;
            p1_reg   <= p1_next;
            p2_reg   <= p1_reg;
            idx2_reg <= norm[31:32-N];
            rem2_reg <= norm[RW-1:0];
            p3_reg   <= p2_reg;
            a3_reg   <= rom[idx2_reg];
            d3_reg   <= rom[(N+1)'(idx2_reg) + (N+1)'(1)] - rom[idx2_reg];
            rem3_reg <= rem2_reg;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/ada_div.sv =====
// ada_div: pipelined restoring divider, two quotient bits a stage, with overflow flag
// depends on ada_pkg for widths
module ada_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ada_pkg::NUM_W-1:0] num,
    input  logic [15:0]               den,
    output logic [ada_pkg::QUO_W-1:0] quo,
    output logic                      ovf
);
    import ada_pkg::*;

    localparam int STEPS = QUO_W / DIV_BITS;

    logic [15:0]      rem_reg  [0:STEPS];
    logic [15:0]      rem_next [0:STEPS];
    logic [QUO_W-1:0] low_reg  [0:STEPS];
    logic [QUO_W-1:0] low_next [0:STEPS];
    logic [QUO_W-1:0] q_reg    [0:STEPS];
    logic [QUO_W-1:0] q_next   [0:STEPS];
    logic [15:0]      den_reg  [0:STEPS];
    logic             ovf_reg  [0:STEPS];
    logic             ovf_next;

    // quotient would not fit in 22 bits
    assign ovf_next = {1'b0, num} >= {den, {QUO_W{1'b0}}};

    always_comb
    begin
        logic [15:0]      r;
        logic [16:0]      r17;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] q;
        rem_next[0] = 16'(num[NUM_W-1:QUO_W]);
        low_next[0] = num[QUO_W-1:0];
        q_next[0]   = '0;
        for (int s = 1; s <= STEPS; s++)
        begin
            r  = rem_reg[s-1];
            lo = low_reg[s-1];
            q  = q_reg[s-1];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                r17 = {r, lo[QUO_W-1]};
                lo  = lo << 1;
                if (r17 >= {1'b0, den_reg[s-1]})
                begin
                    r = 16'(r17 - {1'b0, den_reg[s-1]});
                    q = {q[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r = r17[15:0];
                    q = {q[QUO_W-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            low_next[s] = lo;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            low_reg[0] <= low_next[0];
            q_reg[0]   <= q_next[0];
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
            for (int s = 1; s <= STEPS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                q_reg[s]   <= q_next[s];
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quo = q_reg[STEPS];
    assign ovf = ovf_reg[STEPS];

endmodule
